// ===== sv/owbm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and sizes for the one-wire bus master unit.
// ---------------------------------------------------------------------------
package owbm_pkg;

   // tick counter width and configuration register width
   localparam int TICK_COUNT_WIDTH = 10;
   localparam int CFG_W            = 10;
   localparam int CMP_W            = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

   // configuration port layout
   localparam int NUM_REGS   = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS * 4);
   localparam int REG_IDX_W  = $clog2(NUM_REGS);

   // queue depth between the sides
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVER  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WRITE_ONE_LOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_READ_LOW       = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SLOT_RECOVER   = 3'd7;

   // item kinds, also the operation codes
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   typedef logic [TICK_COUNT_WIDTH-1:0] tick_type;
   typedef logic [CFG_W-1:0]            limit_type;
   typedef logic [CMP_W-1:0]            cmp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] write_value;
      logic       bus_level;
   } req_type;

   typedef struct packed {
      logic       bus_release;
      logic       busy_res;
      logic       done_res;
      logic       presence_bit;
      logic [7:0] read_value;
   } rsp_type;

   // classified item handed from front to engine
   typedef struct packed {
      logic       is_tick;
      logic [1:0] op;
      logic [7:0] write_value;
      logic       bus_level;
   } item_type;

   typedef struct packed {
      limit_type reset_low;
      limit_type presence_wait;
      limit_type reset_recover;
      limit_type write_zero_low;
      limit_type write_one_low;
      limit_type read_low;
      limit_type read_sample;
      limit_type slot_recover;
   } cfg_type;

endpackage
`default_nettype wire

// ===== sv/owbm_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// owbm_front
// Accepts items, classifies them as tick or command and holds them in a
// short queue for the engine.
// ---------------------------------------------------------------------------
module owbm_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  owbm_pkg::req_type   req_item,
   output logic                item_valid,
   output owbm_pkg::item_type  item,
   input  wire                 item_pop
);

   owbm_pkg::item_type                     mem_ff [owbm_pkg::QDEPTH];
   logic [owbm_pkg::QPTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [owbm_pkg::QPTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [owbm_pkg::QCNT_W-1:0]            count_ff, count_in;
   owbm_pkg::item_type                     cls;
   logic                                   do_push;
   logic                                   do_pop;

   // classify the incoming item
   always_comb begin
      cls.is_tick     = (req_item.kind == owbm_pkg::KIND_TICK);
      cls.op          = req_item.kind;
      cls.write_value = req_item.write_value;
      cls.bus_level   = req_item.bus_level;
   end

   assign full       = (count_ff == owbm_pkg::QCNT_W'(owbm_pkg::QDEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + owbm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + owbm_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + owbm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - owbm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ===== sv/owbm_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// owbm_engine
// Bus timing engine: advances the reset, write and read slot sequences by
// one classified item per cycle while item_fire is high; forms the result.
// ---------------------------------------------------------------------------
module owbm_engine (
   input  wire                 clock,
   input  wire                 reset,
   input  owbm_pkg::cfg_type   cfg,
   input  wire                 item_fire,
   input  owbm_pkg::item_type  item,
   output owbm_pkg::rsp_type   rsp
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LOW  = 3'd1;
   localparam logic [2:0] PH_WAIT = 3'd2;
   localparam logic [2:0] PH_REC  = 3'd3;
   localparam logic [2:0] PH_GAP  = 3'd4;

   logic [2:0]          phase_ff, phase_in;
   logic [1:0]          op_ff, op_in;
   owbm_pkg::tick_type  cnt_ff, cnt_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic                presence_ff, presence_in;
   logic [7:0]          read_ff, read_in;
   logic                drive_ff, drive_in;

   owbm_pkg::limit_type lim;
   owbm_pkg::tick_type  cnt_next;
   logic                over;
   logic                done;
   logic                rec_go;
   owbm_pkg::limit_type rec_lim;
   logic                slot_end;

   // limit of the running phase
   always_comb begin
      case (phase_ff)
         PH_LOW: begin
            if (op_ff == owbm_pkg::KIND_RESET) begin
               lim = cfg.reset_low;
            end else if (op_ff == owbm_pkg::KIND_WRITE) begin
               lim = shift_ff[0] ? cfg.write_one_low : cfg.write_zero_low;
            end else begin
               lim = cfg.read_low;
            end
         end
         PH_WAIT: begin
            lim = (op_ff == owbm_pkg::KIND_RESET) ? cfg.presence_wait : cfg.read_sample;
         end
         PH_REC: begin
            lim = (op_ff == owbm_pkg::KIND_RESET) ? cfg.reset_recover : cfg.slot_recover;
         end
         default: begin
            lim = '0;
         end
      endcase
   end

   // saturating tick count and end of period; a limit above the counter
   // range ends the period when the counter saturates
   assign cnt_next = (cnt_ff != '1) ? cnt_ff + owbm_pkg::tick_type'(1) : cnt_ff;
   assign over     = (owbm_pkg::cmp_type'(cnt_next) >= owbm_pkg::cmp_type'(lim)) ||
                     (cnt_next == '1);

   // sequence step for one item
   always_comb begin
      phase_in    = phase_ff;
      op_in       = op_ff;
      cnt_in      = cnt_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      read_in     = read_ff;
      drive_in    = drive_ff;
      done        = 1'b0;
      rec_go      = 1'b0;
      rec_lim     = '0;
      slot_end    = 1'b0;
      if (item_fire) begin
         if (!item.is_tick) begin
            // command, taken only while idle
            if (phase_ff == PH_IDLE) begin
               op_in    = item.op;
               bit_in   = '0;
               shift_in = (item.op == owbm_pkg::KIND_WRITE) ? item.write_value : 8'h00;
               drive_in = 1'b0;
               phase_in = PH_LOW;
               cnt_in   = '0;
            end
         end else begin
            case (phase_ff)
               PH_LOW: begin
                  cnt_in = cnt_next;
                  if (over) begin
                     drive_in = 1'b1;
                     if (op_ff == owbm_pkg::KIND_RESET) begin
                        phase_in = PH_WAIT;
                        cnt_in   = '0;
                     end else if (op_ff == owbm_pkg::KIND_WRITE) begin
                        if (shift_ff[0]) begin
                           rec_go  = 1'b1;
                           rec_lim = cfg.slot_recover;
                        end else begin
                           slot_end = 1'b1;
                        end
                     end else if (cfg.read_sample == '0) begin
                        shift_in = {item.bus_level, shift_ff[7:1]};
                        rec_go   = 1'b1;
                        rec_lim  = cfg.slot_recover;
                     end else begin
                        phase_in = PH_WAIT;
                        cnt_in   = '0;
                     end
                  end
               end
               PH_WAIT: begin
                  cnt_in = cnt_next;
                  if (over) begin
                     if (op_ff == owbm_pkg::KIND_RESET) begin
                        presence_in = item.bus_level;
                        rec_go      = 1'b1;
                        rec_lim     = cfg.reset_recover;
                     end else begin
                        shift_in = {item.bus_level, shift_ff[7:1]};
                        rec_go   = 1'b1;
                        rec_lim  = cfg.slot_recover;
                     end
                  end
               end
               PH_REC: begin
                  cnt_in = cnt_next;
                  if (over) begin
                     slot_end = 1'b1;
                  end
               end
               PH_GAP: begin
                  drive_in = 1'b0;
                  phase_in = PH_LOW;
                  cnt_in   = '0;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            // enter recovery, skipped when its length is zero
            if (rec_go) begin
               drive_in = 1'b1;
               if (rec_lim == '0) begin
                  slot_end = 1'b1;
               end else begin
                  phase_in = PH_REC;
                  cnt_in   = '0;
               end
            end
            // end of a slot or of the reset sequence
            if (slot_end) begin
               drive_in = 1'b1;
               if ((op_ff == owbm_pkg::KIND_RESET) || (bit_ff == 3'd7)) begin
                  if (op_ff == owbm_pkg::KIND_READ) begin
                     read_in = shift_in;
                  end
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  bit_in = bit_ff + 3'd1;
                  if (op_ff == owbm_pkg::KIND_WRITE) begin
                     shift_in = {1'b0, shift_in[7:1]};
                  end
                  phase_in = PH_GAP;
               end
            end
         end
      end
   end

   // result item reflects the state after the item
   always_comb begin
      rsp.bus_release  = drive_in;
      rsp.busy_res     = (phase_in != PH_IDLE);
      rsp.done_res     = done;
      rsp.presence_bit = presence_in;
      rsp.read_value   = read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         op_ff       <= '0;
         cnt_ff      <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b1;
         read_ff     <= '0;
         drive_ff    <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         cnt_ff      <= cnt_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         read_ff     <= read_in;
         drive_ff    <= drive_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/owbm_rsp_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// owbm_rsp_queue
// Short result queue that parts the engine from the result receiver.
// ---------------------------------------------------------------------------
module owbm_rsp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_push,
   input  owbm_pkg::rsp_type   in_item,
   output logic                in_full,
   output logic                empty,
   input  wire                 pop,
   output owbm_pkg::rsp_type   rsp_item
);

   owbm_pkg::rsp_type               mem_ff [owbm_pkg::QDEPTH];
   logic [owbm_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [owbm_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [owbm_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign in_full  = (count_ff == owbm_pkg::QCNT_W'(owbm_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_item = mem_ff[rd_ptr_ff];
   assign do_push  = in_push && !in_full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + owbm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == owbm_pkg::QPTR_W'(owbm_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + owbm_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + owbm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - owbm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/one_wire_bus_master_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// one_wire_bus_master_unit
// One-wire bus master timed by tick items, with a register file for the
// slot and reset pulse lengths.
// ---------------------------------------------------------------------------
// usage
//   input items enter on push/full with req_item: a tick (one microsecond)
//   or a reset, write-byte or read-byte command; commands are ignored while
//   an operation runs. each accepted item gives exactly one result item on
//   empty/pop with rsp_item: wire drive, busy, done, presence and read byte.
//   an accepted item is registered in the input queue, steps the engine, and
//   its result is registered in the result queue before it can be popped.
//   throughput: one item per clock while the result queue has room, set by
//   the state update of the timing engine.
//   a two-entry queue sits in front of and behind the engine; when the
//   receiver stalls the result queue fills, then the input queue, then
//   full rises. no item is dropped.
//   reset: both queues empty, bus released, presence reads one, read byte
//   zero, registers at their default pulse lengths. no clearing pass.
//   registers are written over the csr port at byte address 4*index and
//   should be changed only while the block is idle.
// ---------------------------------------------------------------------------
module one_wire_bus_master_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   push,
   output logic                                  full,
   input  owbm_pkg::req_type                     req_item,
   output logic                                  empty,
   input  wire                                   pop,
   output owbm_pkg::rsp_type                     rsp_item,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [owbm_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  [owbm_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [owbm_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   owbm_pkg::cfg_type                cfg_ff, cfg_in;
   logic                             csr_write;
   logic [owbm_pkg::REG_IDX_W-1:0]   csr_index;
   owbm_pkg::limit_type              csr_value;
   owbm_pkg::limit_type              rd_value;
   logic                             item_valid;
   owbm_pkg::item_type               item;
   logic                             eng_fire;
   owbm_pkg::rsp_type                eng_rsp;
   logic                             rsp_full;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[owbm_pkg::CSR_ADDR_W-1:2];
   assign csr_value = pwdata[owbm_pkg::CFG_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            owbm_pkg::REG_RESET_LOW:      cfg_in.reset_low      = csr_value;
            owbm_pkg::REG_PRESENCE_WAIT:  cfg_in.presence_wait  = csr_value;
            owbm_pkg::REG_RESET_RECOVER:  cfg_in.reset_recover  = csr_value;
            owbm_pkg::REG_WRITE_ZERO_LOW: cfg_in.write_zero_low = csr_value;
            owbm_pkg::REG_WRITE_ONE_LOW:  cfg_in.write_one_low  = csr_value;
            owbm_pkg::REG_READ_LOW:       cfg_in.read_low       = csr_value;
            owbm_pkg::REG_READ_SAMPLE:    cfg_in.read_sample    = csr_value;
            owbm_pkg::REG_SLOT_RECOVER:   cfg_in.slot_recover   = csr_value;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         owbm_pkg::REG_RESET_LOW:      rd_value = cfg_ff.reset_low;
         owbm_pkg::REG_PRESENCE_WAIT:  rd_value = cfg_ff.presence_wait;
         owbm_pkg::REG_RESET_RECOVER:  rd_value = cfg_ff.reset_recover;
         owbm_pkg::REG_WRITE_ZERO_LOW: rd_value = cfg_ff.write_zero_low;
         owbm_pkg::REG_WRITE_ONE_LOW:  rd_value = cfg_ff.write_one_low;
         owbm_pkg::REG_READ_LOW:       rd_value = cfg_ff.read_low;
         owbm_pkg::REG_READ_SAMPLE:    rd_value = cfg_ff.read_sample;
         owbm_pkg::REG_SLOT_RECOVER:   rd_value = cfg_ff.slot_recover;
         default:                      rd_value = '0;
      endcase
   end
   assign prdata = owbm_pkg::CSR_DATA_W'(rd_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low      <= owbm_pkg::limit_type'(500);
         cfg_ff.presence_wait  <= owbm_pkg::limit_type'(70);
         cfg_ff.reset_recover  <= owbm_pkg::limit_type'(170);
         cfg_ff.write_zero_low <= owbm_pkg::limit_type'(120);
         cfg_ff.write_one_low  <= owbm_pkg::limit_type'(8);
         cfg_ff.read_low       <= owbm_pkg::limit_type'(5);
         cfg_ff.read_sample    <= owbm_pkg::limit_type'(5);
         cfg_ff.slot_recover   <= owbm_pkg::limit_type'(50);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   owbm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (eng_fire)
   );

   // engine runs whenever an item waits and the result queue has room
   assign eng_fire = item_valid && !rsp_full;

   owbm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_fire (eng_fire),
      .item      (item),
      .rsp       (eng_rsp)
   );

   // result queue
   owbm_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .in_push  (eng_fire),
      .in_item  (eng_rsp),
      .in_full  (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   // an item that finishes an operation leaves the block idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_item.done_res && rsp_item.busy_res))
      else $error("done item still reports busy");

   // the wire is never pulled low while idle
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.busy_res) |-> rsp_item.bus_release)
      else $error("wire pulled low while idle");

   // reset leaves both queues empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule
`default_nettype wire
